FILE: hdl/lsw_pkg.sv
// Shared types, constants, outcode function and microcode table for the segment visibility block.
`timescale 1ns / 1ps

package lsw_pkg;

  // Number of clipping rounds before an open answer is reported as visible.
  localparam int MAX_CLIPS = 4;

  localparam int IN_W     = 16;
  localparam int COORD_W  = 18;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);
  localparam int ROUND_W  = $clog2(MAX_CLIPS + 1);
  localparam int PC_W     = 4;
  localparam int ROM_DEPTH = 1 << PC_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WIDTH_W    = 15;
  localparam int PAD_W      = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEFT   = 3'd0,
    CFG_WINDOW_TOP    = 3'd1,
    CFG_WINDOW_WIDTH  = 3'd2,
    CFG_WINDOW_HEIGHT = 3'd3,
    CFG_EDGE_PADDING  = 3'd4
  } cfg_idx_t;

  localparam logic [3:0] OC_LEFT   = 4'b0001;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_BOTTOM = 4'b0100;
  localparam logic [3:0] OC_TOP    = 4'b1000;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_EITHER_IN,
    COND_SHARED,
    COND_ROUND_MAX,
    COND_DEN_ZERO,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  // One microcode word: jump condition and target, then the datapath strobes.
  typedef struct packed {
    cond_t             cond;
    logic [PC_W-1:0]   target;
    logic              in_rdy;
    logic              ld_in;
    logic              code;
    logic              clr_round;
    logic              setup;
    logic              mul;
    logic              div_start;
    logic              update;
    logic              emit;
    logic              set_vis;
    logic              vis_val;
  } ucode_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic ld_in;
    logic code;
    logic clr_round;
    logic setup;
    logic mul;
    logic div_start;
    logic update;
    logic emit;
    logic set_vis;
    logic vis_val;
  } ctrl_t;

  // Conditions from the datapath back to the sequencer.
  typedef struct packed {
    logic either_in;
    logic shared;
    logic round_max;
    logic den_zero;
    logic div_busy;
    logic out_busy;
  } stat_t;

  localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] PC_TEST  = 4'd2;
  localparam logic [PC_W-1:0] PC_DIVW  = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd12;

  function automatic logic [3:0] outcode(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic signed [COORD_W-1:0] l,
                                         input logic signed [COORD_W-1:0] r,
                                         input logic signed [COORD_W-1:0] t,
                                         input logic signed [COORD_W-1:0] b);
    logic [3:0] c;
    c = 4'b0000;
    if (x < l) c = c | OC_LEFT;
    else if (x > r) c = c | OC_RIGHT;
    if (y < t) c = c | OC_TOP;
    else if (y > b) c = c | OC_BOTTOM;
    return c;
  endfunction

  function automatic ucode_t uword(input cond_t cond, input logic [PC_W-1:0] target);
    ucode_t w;
    w = '0;
    w.cond = cond;
    w.target = target;
    return w;
  endfunction

  // The control program. Falling through a step moves to the next address.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      4'd0: begin
        w = uword(COND_NO_INPUT, PC_WAIT);
        w.in_rdy = 1'b1;
        w.ld_in = 1'b1;
      end
      4'd1: begin
        w = uword(COND_NEVER, PC_WAIT);
        w.code = 1'b1;
        w.clr_round = 1'b1;
      end
      4'd2: begin
        w = uword(COND_EITHER_IN, PC_EMIT);
        w.set_vis = 1'b1;
        w.vis_val = 1'b1;
      end
      4'd3: begin
        w = uword(COND_SHARED, PC_EMIT);
        w.set_vis = 1'b1;
        w.vis_val = 1'b0;
      end
      4'd4: begin
        w = uword(COND_ROUND_MAX, PC_EMIT);
        w.set_vis = 1'b1;
        w.vis_val = 1'b1;
      end
      4'd5: begin
        w = uword(COND_NEVER, PC_WAIT);
        w.setup = 1'b1;
      end
      4'd6: begin
        w = uword(COND_DEN_ZERO, PC_EMIT);
        w.set_vis = 1'b1;
        w.vis_val = 1'b1;
      end
      4'd7: begin
        w = uword(COND_NEVER, PC_WAIT);
        w.mul = 1'b1;
      end
      4'd8: begin
        w = uword(COND_NEVER, PC_WAIT);
        w.div_start = 1'b1;
      end
      4'd9: begin
        w = uword(COND_DIV_BUSY, PC_DIVW);
      end
      4'd10: begin
        w = uword(COND_NEVER, PC_WAIT);
        w.update = 1'b1;
      end
      4'd11: begin
        w = uword(COND_ALWAYS, PC_TEST);
        w.code = 1'b1;
      end
      4'd12: begin
        w = uword(COND_OUT_BUSY, PC_EMIT);
        w.emit = 1'b1;
      end
      default: begin
        w = uword(COND_ALWAYS, PC_WAIT);
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/lsw_in_if.sv
// Input channel interface: one line segment per transaction.
`timescale 1ns / 1ps

interface lsw_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        start_x;
  logic signed [15:0]        start_y;
  logic signed [15:0]        end_x;
  logic signed [15:0]        end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface

FILE: hdl/lsw_out_if.sv
// Result channel interface: one visibility flag per transaction.
`timescale 1ns / 1ps

interface lsw_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, output visible, input ready);
  modport sink (input valid, input visible, output ready);
endinterface

FILE: hdl/lsw_divider.sv
// Radix-2 restoring signed divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps

module lsw_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [lsw_pkg::PROD_W-1:0] dividend,
  input  logic signed [lsw_pkg::DIFF_W-1:0] divisor,
  output logic                              busy,
  output logic signed [lsw_pkg::PROD_W-1:0] quotient
);
  import lsw_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIFF_W-1:0]    rem_r, rem_nxt;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [DIFF_W-1:0]    dvsr_r, dvsr_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIFF_W:0]      shifted;
  logic                 fits;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvsr_nxt = dvsr_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, quo_r[PROD_W-1]};
    fits     = shifted >= {1'b0, dvsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(PROD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
      dvsr_nxt = divisor[DIFF_W-1] ? DIFF_W'(-divisor) : DIFF_W'(divisor);
      neg_nxt  = dividend[PROD_W-1] ^ divisor[DIFF_W-1];
    end else if (busy_r) begin
      rem_nxt = fits ? DIFF_W'(shifted - {1'b0, dvsr_r}) : shifted[DIFF_W-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvsr_r <= dvsr_nxt;
    neg_r  <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? $signed(-quo_r) : $signed(quo_r);

endmodule

FILE: hdl/lsw_datapath.sv
// Datapath: coordinate and bound registers, outcodes, multiplier, divider and result register.
`timescale 1ns / 1ps

module lsw_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lsw_pkg::ctrl_t                        ctrl,
  output lsw_pkg::stat_t                        stat,
  input  logic signed [lsw_pkg::IN_W-1:0]       start_x,
  input  logic signed [lsw_pkg::IN_W-1:0]       start_y,
  input  logic signed [lsw_pkg::IN_W-1:0]       end_x,
  input  logic signed [lsw_pkg::IN_W-1:0]       end_y,
  input  logic signed [lsw_pkg::IN_W-1:0]       window_left,
  input  logic signed [lsw_pkg::IN_W-1:0]       window_top,
  input  logic [lsw_pkg::WIDTH_W-1:0]           window_width,
  input  logic [lsw_pkg::WIDTH_W-1:0]           window_height,
  input  logic [lsw_pkg::PAD_W-1:0]             edge_padding,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_visible
);
  import lsw_pkg::*;

  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [COORD_W-1:0] bl_r, br_r, bt_r, bb_r;
  logic [3:0]                c0_r, c1_r;
  logic [ROUND_W-1:0]        round_r;
  logic                      axis_tb_r;
  logic signed [COORD_W-1:0] edge_r;
  logic signed [DIFF_W-1:0]  den_r, fa_r, fb_r;
  logic signed [PROD_W-1:0]  num_r;
  logic                      vis_r;
  logic                      out_valid_r, out_vis_r;

  logic                      tb;
  logic signed [COORD_W-1:0] edge_sel;
  logic signed [DIFF_W-1:0]  dx, dy, fb_sel;
  logic                      div_busy;
  logic signed [PROD_W-1:0]  quo;

  assign tb = |(c0_r & (OC_TOP | OC_BOTTOM));
  assign dx = DIFF_W'(x1_r) - DIFF_W'(x0_r);
  assign dy = DIFF_W'(y1_r) - DIFF_W'(y0_r);

  always_comb begin
    if (tb) edge_sel = |(c0_r & OC_TOP) ? bt_r : bb_r;
    else    edge_sel = |(c0_r & OC_RIGHT) ? br_r : bl_r;
    fb_sel = DIFF_W'(edge_sel) - (tb ? DIFF_W'(y0_r) : DIFF_W'(x0_r));
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      x0_r <= COORD_W'(start_x);
      y0_r <= COORD_W'(start_y);
      x1_r <= COORD_W'(end_x);
      y1_r <= COORD_W'(end_y);
      bl_r <= COORD_W'(window_left) - COORD_W'(edge_padding);
      br_r <= COORD_W'(window_left) + COORD_W'(window_width) + COORD_W'(edge_padding);
      bt_r <= COORD_W'(window_top) - COORD_W'(edge_padding);
      bb_r <= COORD_W'(window_top) + COORD_W'(window_height) + COORD_W'(edge_padding);
    end else if (ctrl.update) begin
      if (axis_tb_r) begin
        x0_r <= x0_r + quo[COORD_W-1:0];
        y0_r <= edge_r;
      end else begin
        y0_r <= y0_r + quo[COORD_W-1:0];
        x0_r <= edge_r;
      end
    end
    if (ctrl.code) begin
      c0_r <= outcode(x0_r, y0_r, bl_r, br_r, bt_r, bb_r);
      c1_r <= outcode(x1_r, y1_r, bl_r, br_r, bt_r, bb_r);
    end
    if (ctrl.clr_round) round_r <= '0;
    else if (ctrl.update) round_r <= round_r + 1'b1;
    if (ctrl.setup) begin
      axis_tb_r <= tb;
      edge_r    <= edge_sel;
      den_r     <= tb ? dy : dx;
      fa_r      <= tb ? dx : dy;
      fb_r      <= fb_sel;
    end
    if (ctrl.mul) num_r <= fa_r * fb_r;
    if (ctrl.set_vis) vis_r <= ctrl.vis_val;
    if (ctrl.emit) out_vis_r <= vis_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  lsw_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    stat.either_in = (c0_r == 4'b0000) || (c1_r == 4'b0000);
    stat.shared    = |(c0_r & c1_r);
    stat.round_max = round_r >= ROUND_W'(MAX_CLIPS);
    stat.den_zero  = den_r == '0;
    stat.div_busy  = div_busy;
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_vis_r;

endmodule

FILE: hdl/lsw_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module lsw_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lsw_pkg::stat_t  stat,
  output lsw_pkg::ctrl_t  ctrl
);
  import lsw_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          word;
  logic            taken;

  assign word = ucode_rom(pc_r);

  always_comb begin
    case (word.cond)
      COND_NEVER:     taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_INPUT:  taken = !in_valid;
      COND_EITHER_IN: taken = stat.either_in;
      COND_SHARED:    taken = stat.shared;
      COND_ROUND_MAX: taken = stat.round_max;
      COND_DEN_ZERO:  taken = stat.den_zero;
      COND_DIV_BUSY:  taken = stat.div_busy;
      COND_OUT_BUSY:  taken = stat.out_busy;
      default:        taken = 1'b0;
    endcase
    pc_nxt = taken ? word.target : pc_r + 1'b1;

    ctrl.ld_in     = word.ld_in && in_valid;
    ctrl.code      = word.code;
    ctrl.clr_round = word.clr_round;
    ctrl.setup     = word.setup;
    ctrl.mul       = word.mul;
    ctrl.div_start = word.div_start;
    ctrl.update    = word.update;
    ctrl.emit      = word.emit && !stat.out_busy;
    ctrl.set_vis   = word.set_vis && taken;
    ctrl.vis_val   = word.vis_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= PC_WAIT;
    else        pc_r <= pc_nxt;
  end

  assign in_ready = word.in_rdy;

endmodule

FILE: hdl/line_segment_window_visibility.sv
// Top level of the line segment window visibility block.
`timescale 1ns / 1ps

// Decides whether a line segment may touch a padded rectangular window.
// Segments arrive on in_ch as valid/ready transactions carrying both
// endpoints; each segment yields exactly one transaction on out_ch with the
// visible flag. The window and its padding are written through the cfg port
// (write enable, index, data) and must only change while the block is idle.
// Items are handled one at a time under a small microcoded sequencer.
// A segment needs up to MAX_CLIPS (four) clipping rounds, each dominated by
// the radix-2 divider; one settled by its outcodes alone needs no round.
// The result sits in an output register: if the receiver stalls, the block
// finishes a following segment up to its result step and waits there, and
// in_ch.ready is high whenever the sequencer waits for a new segment.
// Synchronous active-low reset clears the sequencer, the divider and the
// output valid flag, and sets all window registers to zero.
module line_segment_window_visibility (
  input  logic                               clk,
  input  logic                               rst_n,
  lsw_in_if.sink                             in_ch,
  lsw_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [lsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lsw_pkg::*;

  // Window registers. Writes to an index past the list are dropped.
  logic signed [IN_W-1:0] win_left_r, win_top_r;
  logic [WIDTH_W-1:0]     win_width_r, win_height_r;
  logic [PAD_W-1:0]       pad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_top_r    <= '0;
      win_width_r  <= '0;
      win_height_r <= '0;
      pad_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LEFT:   win_left_r   <= cfg_wdata;
        CFG_WINDOW_TOP:    win_top_r    <= cfg_wdata;
        CFG_WINDOW_WIDTH:  win_width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_WINDOW_HEIGHT: win_height_r <= cfg_wdata[WIDTH_W-1:0];
        CFG_EDGE_PADDING:  pad_r        <= cfg_wdata[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  ctrl_t ctrl;
  stat_t stat;

  // The sequencer walks the control program; the datapath does the math.
  lsw_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  lsw_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .start_x       (in_ch.start_x),
    .start_y       (in_ch.start_y),
    .end_x         (in_ch.end_x),
    .end_y         (in_ch.end_y),
    .window_left   (win_left_r),
    .window_top    (win_top_r),
    .window_width  (win_width_r),
    .window_height (win_height_r),
    .edge_padding  (pad_r),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_visible   (out_ch.visible)
  );

`ifndef ASSERT_OFF
  // Once a segment is taken, the block is busy with it for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // The divider is never restarted while a division is still running.
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // A new result appears only from the result step of the program.
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctrl.emit))
    else $error("result valid without an emit step");
`endif

endmodule

FILE: test/lsw_checker.sv
// Checker for the segment visibility block: mirrors the window registers, predicts and compares.
`timescale 1ns / 1ps

module lsw_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [15:0]             in_start_x,
  input  logic signed [15:0]             in_start_y,
  input  logic signed [15:0]             in_end_x,
  input  logic signed [15:0]             in_end_y,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_visible,
  input  logic                           cfg_we,
  input  logic [lsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import lsw_pkg::*;

  // Shadow copy of the window registers at their own widths.
  logic signed [15:0] win_left;
  logic signed [15:0] win_top;
  logic [14:0]        win_width;
  logic [14:0]        win_height;
  logic [9:0]         win_pad;

  logic pending_verdicts[$];
  int   mismatches;
  int   result_no;
  logic want;

  function automatic logic [3:0] region_code(input longint x, input longint y,
                                             input longint lx, input longint hx,
                                             input longint ly, input longint hy);
    logic [3:0] c;
    c = 4'b0000;
    if (x < lx) c = c | OC_LEFT;
    else if (x > hx) c = c | OC_RIGHT;
    if (y < ly) c = c | OC_TOP;
    else if (y > hy) c = c | OC_BOTTOM;
    return c;
  endfunction

  // Clips endpoint 0 toward the padded window until outcodes, a zero divisor or MAX_CLIPS settle the answer.
  function automatic logic segment_may_show(input logic signed [15:0] sx,
                                            input logic signed [15:0] sy,
                                            input logic signed [15:0] ex,
                                            input logic signed [15:0] ey);
    longint lx, hx, ly, hy;
    longint x0, y0, x1, y1;
    longint den, bound;
    logic [3:0] c0, c1;
    logic verdict;
    bit settled;
    int rnd;
    lx = longint'(win_left) - longint'(win_pad);
    hx = longint'(win_left) + longint'(win_width) + longint'(win_pad);
    ly = longint'(win_top) - longint'(win_pad);
    hy = longint'(win_top) + longint'(win_height) + longint'(win_pad);
    x0 = longint'(sx);
    y0 = longint'(sy);
    x1 = longint'(ex);
    y1 = longint'(ey);
    c0 = region_code(x0, y0, lx, hx, ly, hy);
    c1 = region_code(x1, y1, lx, hx, ly, hy);
    verdict = 1'b1;
    settled = 1'b0;
    rnd = 0;
    while (!settled) begin
      if (c0 == 4'b0000 || c1 == 4'b0000) begin
        verdict = 1'b1;
        settled = 1'b1;
      end else if ((c0 & c1) != 4'b0000) begin
        verdict = 1'b0;
        settled = 1'b1;
      end else if (rnd >= MAX_CLIPS) begin
        verdict = 1'b1;
        settled = 1'b1;
      end else if ((c0 & (OC_TOP | OC_BOTTOM)) != 4'b0000) begin
        bound = ((c0 & OC_TOP) != 4'b0000) ? ly : hy;
        den = y1 - y0;
        if (den == 0) begin
          verdict = 1'b1;
          settled = 1'b1;
        end else begin
          x0 = x0 + ((x1 - x0) * (bound - y0)) / den;
          y0 = bound;
        end
      end else begin
        bound = ((c0 & OC_RIGHT) != 4'b0000) ? hx : lx;
        den = x1 - x0;
        if (den == 0) begin
          verdict = 1'b1;
          settled = 1'b1;
        end else begin
          y0 = y0 + ((y1 - y0) * (bound - x0)) / den;
          x0 = bound;
        end
      end
      if (!settled) begin
        c0 = region_code(x0, y0, lx, hx, ly, hy);
        rnd++;
      end
    end
    return verdict;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      win_left = '0;
      win_top = '0;
      win_width = '0;
      win_height = '0;
      win_pad = '0;
      pending_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LEFT:   win_left = cfg_wdata[15:0];
          CFG_WINDOW_TOP:    win_top = cfg_wdata[15:0];
          CFG_WINDOW_WIDTH:  win_width = cfg_wdata[WIDTH_W-1:0];
          CFG_WINDOW_HEIGHT: win_height = cfg_wdata[WIDTH_W-1:0];
          CFG_EDGE_PADDING:  win_pad = cfg_wdata[PAD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_verdicts.insert(pending_verdicts.size(),
                                segment_may_show(in_start_x, in_start_y,
                                                 in_end_x, in_end_y));
      end
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d arrived with no segment waiting: visible=%b",
                     result_no, out_visible);
          end
        end else begin
          want = pending_verdicts.pop_front();
          if (out_visible !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: visible expected %b, got %b",
                       result_no, want, out_visible);
            end
          end
        end
        result_no++;
      end
    end
    pending <= pending_verdicts.size();
    fail_count <= mismatches;
  end

endmodule

FILE: test/tb_top.sv
// Testbench top: drives segments and window settings into the block and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
  import lsw_pkg::*;

  // This limit leaves several times the worst run of roughly 700 segments,
  // with receiver stalls on top.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 656;
  localparam int NUM_PHASES   = 8;
  localparam int DRAIN_CYCLES = 220;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // When set, neither side idles: the long stretch of back-to-back traffic.
  bit steady;

  // Current window as written, kept only to aim random segments at it.
  int cur_left, cur_top, cur_width, cur_height, cur_pad;

  int fail_count;
  int pending;

  lsw_in_if  in_ch();
  lsw_out_if out_ch();

  line_segment_window_visibility u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // The checker only watches: every transaction on both channels and every
  // register write goes through it.
  lsw_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_start_x (in_ch.start_x),
    .in_start_y (in_ch.start_y),
    .in_end_x   (in_ch.end_x),
    .in_end_y   (in_ch.end_y),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_visible(out_ch.visible),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls about a quarter of the time, except in the steady stretch.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
  end

  // The cycle counter that ends a hung run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic bit sender_idles();
    return !steady && ($urandom_range(0, 99) < 26);
  endfunction

  // Picks one coordinate: mostly around the span [lo, hi] so that segments
  // cross, graze and miss the window, sometimes fully random or an extreme.
  function automatic logic signed [15:0] pick_coord(input int lo, input int hi);
    int span, v, roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 16'($urandom);
    if (roll < 28) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    span = hi - lo + 64;
    v = lo - span + int'($urandom_range(0, 3 * span));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  // Offers one segment and returns in the time step of the edge that accepted
  // it. Valid stays high afterwards so that back-to-back segments need no
  // second assignment within one step; an idling next call or the drain lowers it.
  task automatic send_segment(input logic signed [15:0] sx, input logic signed [15:0] sy,
                              input logic signed [15:0] ex, input logic signed [15:0] ey);
    while (sender_idles()) begin
      in_ch.valid   <= 1'b0;
      in_ch.start_x <= 16'($urandom);
      in_ch.start_y <= 16'($urandom);
      in_ch.end_x   <= 16'($urandom);
      in_ch.end_y   <= 16'($urandom);
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.end_x   <= ex;
    in_ch.end_y   <= ey;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random_segment();
    int lx, hx, ly, hy;
    lx = cur_left - cur_pad;
    hx = cur_left + cur_width + cur_pad;
    ly = cur_top - cur_pad;
    hy = cur_top + cur_height + cur_pad;
    send_segment(pick_coord(lx, hx), pick_coord(ly, hy),
                 pick_coord(lx, hx), pick_coord(ly, hy));
  endtask

  // Stops offering segments and waits until every expected result is in.
  // Every segment yields a result, so the block is idle once the last one
  // has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes all five window registers on consecutive edges, then one index
  // beyond the list that the block must ignore. The unused upper bits of the
  // narrow registers carry random values.
  task automatic set_window(input int left, input int top, input int width,
                            input int height, input int pad);
    logic [CFG_IDX_W-1:0]  idx  [6];
    logic [CFG_DATA_W-1:0] word [6];
    idx = '{CFG_WINDOW_LEFT, CFG_WINDOW_TOP, CFG_WINDOW_WIDTH, CFG_WINDOW_HEIGHT,
            CFG_EDGE_PADDING, CFG_EDGE_PADDING + CFG_IDX_W'($urandom_range(1, 3))};
    word[0] = 16'(left);
    word[1] = 16'(top);
    word[2] = {1'($urandom), 15'(width)};
    word[3] = {1'($urandom), 15'(height)};
    word[4] = {6'($urandom), 10'(pad)};
    word[5] = 16'($urandom);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= word[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_left   = int'($signed(16'(left)));
    cur_top    = int'($signed(16'(top)));
    cur_width  = int'(15'(width));
    cur_height = int'(15'(height));
    cur_pad    = int'(10'(pad));
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.end_x   <= '0;
    in_ch.end_y   <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_WINDOW_LEFT;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    steady        = 1'b0;
    cur_left = 0;
    cur_top = 0;
    cur_width = 0;
    cur_height = 0;
    cur_pad = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window: a single point at the origin.
    send_segment(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_segment(16'sd5, -16'sd3, -16'sd5, 16'sd3);
    send_segment(16'sd1, 16'sd1, 16'sd9, 16'sd1);
    drain();

    // A moderate window whose padded bounds are x -110..110, y -60..60.
    set_window(-100, -50, 200, 100, 10);
    send_segment(-16'sd110, -16'sd60, -16'sd110, -16'sd60); // on the padded corner
    send_segment(-16'sd111, 16'sd0, -16'sd400, 16'sd20);    // both left of the window
    send_segment(16'sd111, 16'sd0, 16'sd500, 16'sd0);       // both right
    send_segment(16'sd0, -16'sd61, 16'sd0, -16'sd32768);    // both above
    send_segment(16'sd0, 16'sd61, 16'sd0, 16'sd32767);      // both below
    send_segment(-16'sd500, 16'sd0, 16'sd500, 16'sd0);      // horizontal through
    send_segment(16'sd0, -16'sd500, 16'sd0, 16'sd500);      // vertical through
    send_segment(-16'sd500, -16'sd500, 16'sd500, 16'sd500); // diagonal through
    send_segment(-16'sd500, 16'sd200, 16'sd200, -16'sd500); // misses past a corner
    send_segment(16'sd200, -16'sd300, -16'sd300, 16'sd200); // clips into the top edge
    send_segment(-16'sd111, -16'sd61, 16'sd111, 16'sd61);   // corner to corner
    send_segment(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_segment(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_segment(-16'sd32768, 16'sd0, 16'sd32767, 16'sd1);
    send_segment(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
    drain();

    // Largest window and padding, anchored at the most negative corner.
    set_window(-32768, -32768, 32767, 32767, 1023);
    send_segment(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_segment(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_segment(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    drain();

    // A zero-size window without padding at the most positive corner.
    set_window(32767, 32767, 0, 0, 0);
    send_segment(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_segment(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32766);
    send_segment(16'sd0, 16'sd0, 16'sd100, 16'sd100);
    drain();

    // Random phases, each under its own window setting. Phase four runs with
    // no idling on either side.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      steady = (phase == 4);
      case (phase)
        0: set_window($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 32767), $urandom_range(0, 32767),
                      $urandom_range(0, 1023));
        1: set_window($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                      $urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 50));
        2: set_window(-32768, -32768, 32767, 32767, 1023);
        3: set_window(0, 0, 0, 0, 0);
        4: set_window($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000,
                      $urandom_range(0, 3000), $urandom_range(0, 3000),
                      $urandom_range(0, 1023));
        5: set_window(32767, -32768, 0, 32767, 1023);
        6: set_window($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                      $urandom_range(0, 20), $urandom_range(0, 20), 0);
        default: set_window(-32768, 32767, 32767, 0, $urandom_range(0, 1023));
      endcase
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
        send_random_segment();
      end
      drain();
    end
    steady = 1'b0;

    // Let the block run as long as one slow segment could, to catch any
    // result that arrives without a segment behind it.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
